>>> rtl/rme_pkg.sv
package rme_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int CURVE_STEPS = 256;
    localparam int STEP_BITS   = $clog2(CURVE_STEPS);
    localparam int FR_BITS     = FRAC_BITS - STEP_BITS;
    localparam int W_BITS      = 31;
    localparam int PCT_BITS    = FRAC_BITS + 1;
    localparam int P_BITS      = 14;

    localparam logic [W_BITS-1:0] W_ONE   = W_BITS'(64'd1 << 30);
    localparam logic [31:0]       SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0]       SAT_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_REF_START    = 3'd0,
        REG_REF_END      = 3'd1,
        REG_TARGET_START = 3'd2,
        REG_TARGET_END   = 3'd3,
        REG_DEC_PLACES   = 3'd4,
        REG_CURVE_KIND   = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        CURVE_LINEAR   = 3'd0,
        CURVE_EASE_IN  = 3'd1,
        CURVE_EASE_OUT = 3'd2,
        CURVE_INSTANT  = 3'd3,
        CURVE_EASE_IO  = 3'd4
    } t_curve;

    typedef logic [CURVE_STEPS:0][W_BITS-1:0] t_curve_tab;

    // Scale factor 10^d for the decimal rounding; five or more places act as four.
    function automatic logic [P_BITS-1:0] f_pow10(logic [2:0] d);
        logic [P_BITS-1:0] p;
        case (d)
            3'd0:    p = P_BITS'(1);
            3'd1:    p = P_BITS'(10);
            3'd2:    p = P_BITS'(100);
            3'd3:    p = P_BITS'(1000);
            default: p = P_BITS'(10000);
        endcase
        return p;
    endfunction

    function automatic logic [63:0] f_isqrt(logic [63:0] op);
        logic [63:0] res;
        logic [63:0] one;
        logic [63:0] o;
        res = '0;
        one = 64'd1 << 62;
        o   = op;
        for (int i = 0; i < 32; i++) begin
            if (one > o) one = one >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (one != 64'd0) begin
                if (o >= res + one) begin
                    o   = o - (res + one);
                    res = (res >> 1) + one;
                end else begin
                    res = res >> 1;
                end
                one = one >> 2;
            end
        end
        return res;
    endfunction

    // log2 of n >= 1 with 30 fraction bits, by repeated squaring.
    function automatic logic [63:0] f_log2_q30(logic [63:0] n);
        logic [63:0] m;
        logic [63:0] r;
        int          e;
        e = 0;
        for (int j = 0; j < 63; j++) begin
            if ((n >> (e + 1)) != 64'd0) e++;
        end
        m = (n << 30) >> e;
        r = '0;
        for (int k = 1; k <= 30; k++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                r = r | (64'd1 << (30 - k));
            end
        end
        return (64'(e) << 30) + r;
    endfunction

    function automatic t_curve_tab f_ease_in_tab();
        t_curve_tab  tab;
        logic [63:0] roots [0:30];
        logic [63:0] lg_s;
        logic [63:0] a;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] g;
        logic [63:0] res;
        logic [63:0] v;
        roots[0] = '0;
        roots[1] = f_isqrt(64'd1 << 61);
        for (int k = 2; k <= 30; k++) roots[k] = f_isqrt(roots[k-1] << 30);
        lg_s = f_log2_q30(64'(CURVE_STEPS));
        for (int i = 0; i <= CURVE_STEPS; i++) begin
            if (i == 0) begin
                v = '0;
            end else if (i == CURVE_STEPS) begin
                v = 64'd1 << 30;
            end else begin
                a = ((lg_s - f_log2_q30(64'(i))) * 64'd1675 + 64'd500) / 64'd1000;
                n = a >> 30;
                f = a & ((64'd1 << 30) - 64'd1);
                if (n > 64'd40) begin
                    v = '0;
                end else if (f == 64'd0) begin
                    v = (64'd1 << 30) >> n;
                end else begin
                    g   = (64'd1 << 30) - f;
                    res = 64'd1 << 30;
                    for (int k = 1; k <= 30; k++) begin
                        if (g[30-k]) res = (res * roots[k]) >> 30;
                    end
                    v = res >> (n + 64'd1);
                end
            end
            tab[i] = v[W_BITS-1:0];
        end
        return tab;
    endfunction

    // sin^2 easing, sine by a Taylor series up to the thirteenth power.
    function automatic t_curve_tab f_ease_io_tab();
        t_curve_tab         tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        t;
        logic [63:0]        s;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int i = 0; i <= CURVE_STEPS; i++) begin
            if (i == 0) begin
                v = '0;
            end else if (i == CURVE_STEPS) begin
                v = 64'd1 << 30;
            end else begin
                x    = (64'hC90F_DAA2 * 64'(i)) / 64'(2 * CURVE_STEPS);
                x2   = (x * x) >> 30;
                term = x;
                sum  = $signed(x);
                for (int n = 1; n <= 6; n++) begin
                    t = (term * x2) >> 30;
                    case (n)
                        1:       term = t / 64'd6;
                        2:       term = t / 64'd20;
                        3:       term = t / 64'd42;
                        4:       term = t / 64'd72;
                        5:       term = t / 64'd110;
                        default: term = t / 64'd156;
                    endcase
                    if ((n & 1) == 1) sum = sum - $signed(term);
                    else              sum = sum + $signed(term);
                end
                if (sum < 0) sum = '0;
                if (sum > $signed(64'd1 << 30)) sum = $signed(64'd1 << 30);
                s = $unsigned(sum);
                v = (s * s) >> 30;
            end
            tab[i] = v[W_BITS-1:0];
        end
        return tab;
    endfunction

    localparam t_curve_tab EASE_IN_TAB = f_ease_in_tab();
    localparam t_curve_tab EASE_IO_TAB = f_ease_io_tab();

endpackage

>>> rtl/rme_curve.sv
module rme_curve (
    input  logic [2:0]                      i_curve,
    input  logic [rme_pkg::PCT_BITS-1:0]    i_pct,
    output logic [rme_pkg::W_BITS-1:0]      o_a,
    output logic [rme_pkg::W_BITS-1:0]      o_b,
    output logic [rme_pkg::FR_BITS-1:0]     o_fr
);

    logic [rme_pkg::STEP_BITS:0]   w_idx;
    logic [rme_pkg::FR_BITS-1:0]   w_fr;
    logic                          w_last;
    logic [rme_pkg::STEP_BITS:0]   w_fa;
    logic [rme_pkg::STEP_BITS:0]   w_fb;
    logic [rme_pkg::STEP_BITS:0]   w_ma;
    logic [rme_pkg::STEP_BITS:0]   w_mb;
    logic [rme_pkg::STEP_BITS:0]   w_steps;

    assign w_steps = (rme_pkg::STEP_BITS+1)'(rme_pkg::CURVE_STEPS);
    assign w_idx   = i_pct[rme_pkg::FRAC_BITS:rme_pkg::FR_BITS];
    assign w_fr    = i_pct[rme_pkg::FR_BITS-1:0];
    assign w_last  = (w_idx == w_steps);

    // At the top of the range the second point is never weighted, so it is simply held.
    assign w_fa = w_idx;
    assign w_fb = w_last ? w_idx : w_idx + 1'b1;
    assign w_ma = w_steps - w_idx;
    assign w_mb = w_last ? w_ma : w_steps - w_idx - 1'b1;

    always_comb begin
        o_fr = w_fr;
        unique case (rme_pkg::t_curve'(i_curve))
            rme_pkg::CURVE_LINEAR: begin
                o_a  = {i_pct, {(rme_pkg::W_BITS-rme_pkg::PCT_BITS){1'b0}}};
                o_b  = o_a;
                o_fr = '0;
            end
            rme_pkg::CURVE_EASE_IN: begin
                o_a = rme_pkg::EASE_IN_TAB[w_fa];
                o_b = rme_pkg::EASE_IN_TAB[w_fb];
            end
            rme_pkg::CURVE_EASE_OUT: begin
                o_a = rme_pkg::W_ONE - rme_pkg::EASE_IN_TAB[w_ma];
                o_b = rme_pkg::W_ONE - rme_pkg::EASE_IN_TAB[w_mb];
            end
            rme_pkg::CURVE_INSTANT: begin
                o_a  = rme_pkg::W_ONE;
                o_b  = rme_pkg::W_ONE;
                o_fr = '0;
            end
            default: begin
                o_a = rme_pkg::EASE_IO_TAB[w_fa];
                o_b = rme_pkg::EASE_IO_TAB[w_fb];
            end
        endcase
    end

endmodule

>>> rtl/range_map_with_easing_top.sv
// Range map with easing curve.
// Input channel (s_axis): one signed Q16.16 reference value per transaction.
// Output channel (m_axis): one signed Q16.16 mapped value per input transaction,
// in the same order.
// Configuration: write i_cfg_wdata to register i_cfg_index while i_cfg_we is
// high; the user must change registers only while no transaction is in flight,
// as the block itself does not enforce it. The datapath is a 40-stage pipeline
// that accepts one transaction every cycle while it has room. The depth is set
// by the 16-stage fraction divider and the 13-stage decimal rounding divider,
// resolving one and four quotient bits per stage respectively.
// Every stage holds a valid bit and advances whenever the stage after it is
// empty or advancing, so bubbles are squeezed out while the receiver stalls and
// input is still taken until the pipeline is full. A stalled result holds.
// Synchronous reset empties the pipeline and restores the register defaults.
module range_map_with_easing_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] ref_value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] mapped_value
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    localparam int DIV1_STEPS   = rme_pkg::FRAC_BITS;
    localparam int DIV2_WIDTH   = 52;
    localparam int DIV2_BITS    = 4;
    localparam int DIV2_STAGES  = DIV2_WIDTH / DIV2_BITS;
    localparam int ST_IN        = 0;
    localparam int ST_CMP       = 1;
    localparam int ST_DIV1      = 2;
    localparam int ST_PCT       = ST_DIV1 + DIV1_STEPS;
    localparam int ST_W         = ST_PCT + 1;
    localparam int ST_MUL       = ST_W + 1;
    localparam int ST_X         = ST_MUL + 1;
    localparam int ST_ABS       = ST_X + 1;
    localparam int ST_PMUL      = ST_ABS + 1;
    localparam int ST_K         = ST_PMUL + 1;
    localparam int ST_DVD       = ST_K + 1;
    localparam int ST_DIV2      = ST_DVD + 1;
    localparam int ST_OUT       = ST_DIV2 + DIV2_STAGES;
    localparam int NSTG         = ST_OUT + 1;

    typedef struct packed {
        logic                               zero_span;
        logic                               ge;
        logic                               neg;
        logic [32:0]                        un;
        logic [32:0]                        ud;
        logic [32:0]                        rem;
        logic [DIV1_STEPS-1:0]              quo;
        logic [rme_pkg::W_BITS-1:0]         ta;
        logic [rme_pkg::W_BITS-1:0]         tb;
        logic [rme_pkg::FR_BITS-1:0]        fr;
        logic [rme_pkg::W_BITS-1:0]         w;
        logic signed [63:0]                 x;
        logic [63:0]                        m;
        logic [45:0]                        hp;
        logic [45:0]                        lp;
        logic [32:0]                        k;
        logic [DIV2_WIDTH-1:0]              dvd;
        logic [rme_pkg::P_BITS-1:0]         rm2;
        logic [DIV2_WIDTH-1:0]              q2;
        logic [31:0]                        res;
    } t_stage;

    logic [31:0] r_ref_start;
    logic [31:0] r_ref_end;
    logic [31:0] r_target_start;
    logic [31:0] r_target_end;
    logic [2:0]  r_dec_places;
    logic [2:0]  r_curve_kind;

    t_stage                     r_stg [NSTG];
    t_stage                     n_stg [NSTG];
    logic [NSTG-1:0]            r_vld;
    logic [NSTG-1:0]            w_rdy;
    logic [rme_pkg::P_BITS-1:0] w_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_start    <= 32'd0;
            r_ref_end      <= 32'd65536;
            r_target_start <= 32'd0;
            r_target_end   <= 32'd65536;
            r_dec_places   <= 3'd1;
            r_curve_kind   <= rme_pkg::CURVE_LINEAR;
        end else if (i_cfg_we) begin
            unique case (rme_pkg::t_reg_idx'(i_cfg_index))
                rme_pkg::REG_REF_START:    r_ref_start    <= i_cfg_wdata;
                rme_pkg::REG_REF_END:      r_ref_end      <= i_cfg_wdata;
                rme_pkg::REG_TARGET_START: r_target_start <= i_cfg_wdata;
                rme_pkg::REG_TARGET_END:   r_target_end   <= i_cfg_wdata;
                rme_pkg::REG_DEC_PLACES:   r_dec_places   <= i_cfg_wdata[2:0];
                rme_pkg::REG_CURVE_KIND:   r_curve_kind   <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    assign w_p = rme_pkg::f_pow10(r_dec_places);

    assign w_rdy[NSTG-1]   = !r_vld[NSTG-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = r_stg[NSTG-1].res;

    generate
        for (genvar k = 0; k < NSTG; k++) begin : g_stg
            if (k < NSTG - 1) begin : g_rdy
                assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_vld[k] <= (k == 0) ? i_s_axis_tvalid : r_vld[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[k]) begin
                    r_stg[k] <= n_stg[k];
                end
            end

            if (k == ST_IN) begin : g_in
                logic signed [32:0] w_num;
                logic signed [32:0] w_den;
                always_comb begin
                    w_num = $signed({i_s_axis_tdata[31], i_s_axis_tdata})
                          - $signed({r_ref_start[31], r_ref_start});
                    w_den = $signed({r_ref_end[31], r_ref_end})
                          - $signed({r_ref_start[31], r_ref_start});
                    n_stg[k]           = '0;
                    n_stg[k].un        = w_num[32] ? 33'(-w_num) : 33'(w_num);
                    n_stg[k].ud        = w_den[32] ? 33'(-w_den) : 33'(w_den);
                    n_stg[k].zero_span = (w_den == 33'sd0);
                end
            end else if (k == ST_CMP) begin : g_cmp
                always_comb begin
                    n_stg[k]     = r_stg[k-1];
                    n_stg[k].ge  = (r_stg[k-1].un >= r_stg[k-1].ud);
                    n_stg[k].rem = r_stg[k-1].un;
                    n_stg[k].quo = '0;
                end
            end else if (k >= ST_DIV1 && k < ST_PCT) begin : g_div1
                // One restoring step of the fraction divider per stage.
                logic [33:0] w_t;
                always_comb begin
                    n_stg[k] = r_stg[k-1];
                    w_t      = {r_stg[k-1].rem, 1'b0};
                    if (w_t >= {1'b0, r_stg[k-1].ud}) begin
                        n_stg[k].rem = 33'(w_t - {1'b0, r_stg[k-1].ud});
                        n_stg[k].quo = {r_stg[k-1].quo[DIV1_STEPS-2:0], 1'b1};
                    end else begin
                        n_stg[k].rem = w_t[32:0];
                        n_stg[k].quo = {r_stg[k-1].quo[DIV1_STEPS-2:0], 1'b0};
                    end
                end
            end else if (k == ST_PCT) begin : g_pct
                logic [rme_pkg::PCT_BITS-1:0] w_pct;
                logic [rme_pkg::W_BITS-1:0]   w_a;
                logic [rme_pkg::W_BITS-1:0]   w_b;
                logic [rme_pkg::FR_BITS-1:0]  w_fr;
                assign w_pct = r_stg[k-1].ge ? rme_pkg::PCT_BITS'(1 << rme_pkg::FRAC_BITS)
                                             : {1'b0, r_stg[k-1].quo};
                rme_curve u_curve (
                    .i_curve (r_curve_kind),
                    .i_pct   (w_pct),
                    .o_a     (w_a),
                    .o_b     (w_b),
                    .o_fr    (w_fr)
                );
                always_comb begin
                    n_stg[k]    = r_stg[k-1];
                    n_stg[k].ta = w_a;
                    n_stg[k].tb = w_b;
                    n_stg[k].fr = w_fr;
                end
            end else if (k == ST_W) begin : g_w
                logic signed [31:0] w_diff;
                logic signed [40:0] w_prod;
                logic signed [40:0] w_sum;
                always_comb begin
                    w_diff = $signed({1'b0, r_stg[k-1].tb}) - $signed({1'b0, r_stg[k-1].ta});
                    w_prod = w_diff * $signed({1'b0, r_stg[k-1].fr});
                    w_sum  = $signed(41'(r_stg[k-1].ta)) + (w_prod >>> rme_pkg::FR_BITS);
                    n_stg[k]   = r_stg[k-1];
                    n_stg[k].w = w_sum[rme_pkg::W_BITS-1:0];
                end
            end else if (k == ST_MUL) begin : g_mul
                logic signed [32:0] w_dts;
                logic signed [64:0] w_prod;
                always_comb begin
                    w_dts  = $signed({r_target_end[31], r_target_end})
                           - $signed({r_target_start[31], r_target_start});
                    w_prod = w_dts * $signed({1'b0, r_stg[k-1].w});
                    n_stg[k]   = r_stg[k-1];
                    n_stg[k].x = w_prod[63:0];
                end
            end else if (k == ST_X) begin : g_x
                logic signed [63:0] w_base;
                always_comb begin
                    w_base     = $signed(64'($signed(r_target_start))) <<< 30;
                    n_stg[k]   = r_stg[k-1];
                    n_stg[k].x = r_stg[k-1].x + w_base;
                end
            end else if (k == ST_ABS) begin : g_abs
                always_comb begin
                    n_stg[k]     = r_stg[k-1];
                    n_stg[k].neg = r_stg[k-1].x[63];
                    n_stg[k].m   = r_stg[k-1].x[63] ? 64'(-r_stg[k-1].x) : 64'(r_stg[k-1].x);
                end
            end else if (k == ST_PMUL) begin : g_pmul
                always_comb begin
                    n_stg[k]    = r_stg[k-1];
                    n_stg[k].hp = 46'(r_stg[k-1].m[63:32]) * 46'(w_p);
                    n_stg[k].lp = 46'(r_stg[k-1].m[31:0]) * 46'(w_p);
                end
            end else if (k == ST_K) begin : g_k
                // Round half away from zero to the kept decimal digit.
                logic [46:0] w_hi;
                always_comb begin
                    w_hi = 47'(r_stg[k-1].hp) + 47'(r_stg[k-1].lp[45:32])
                         + 47'(1 << (rme_pkg::FRAC_BITS - 3));
                    n_stg[k]   = r_stg[k-1];
                    n_stg[k].k = w_hi[46:rme_pkg::FRAC_BITS-2];
                end
            end else if (k == ST_DVD) begin : g_dvd
                always_comb begin
                    n_stg[k]     = r_stg[k-1];
                    n_stg[k].dvd = (DIV2_WIDTH'(r_stg[k-1].k) << rme_pkg::FRAC_BITS)
                                 + DIV2_WIDTH'(w_p >> 1);
                    n_stg[k].rm2 = '0;
                    n_stg[k].q2  = '0;
                end
            end else if (k >= ST_DIV2 && k < ST_OUT) begin : g_div2
                // DIV2_BITS restoring steps of the division by 10^d per stage.
                logic [rme_pkg::P_BITS:0]   w_t;
                logic [rme_pkg::P_BITS-1:0] w_rm;
                logic [DIV2_WIDTH-1:0]      w_dv;
                logic [DIV2_WIDTH-1:0]      w_q;
                always_comb begin
                    w_rm = r_stg[k-1].rm2;
                    w_dv = r_stg[k-1].dvd;
                    w_q  = r_stg[k-1].q2;
                    w_t  = '0;
                    for (int j = 0; j < DIV2_BITS; j++) begin
                        w_t  = {w_rm, w_dv[DIV2_WIDTH-1]};
                        w_dv = {w_dv[DIV2_WIDTH-2:0], 1'b0};
                        if (w_t >= {1'b0, w_p}) begin
                            w_rm = rme_pkg::P_BITS'(w_t - {1'b0, w_p});
                            w_q  = {w_q[DIV2_WIDTH-2:0], 1'b1};
                        end else begin
                            w_rm = w_t[rme_pkg::P_BITS-1:0];
                            w_q  = {w_q[DIV2_WIDTH-2:0], 1'b0};
                        end
                    end
                    n_stg[k]     = r_stg[k-1];
                    n_stg[k].rm2 = w_rm;
                    n_stg[k].dvd = w_dv;
                    n_stg[k].q2  = w_q;
                end
            end else begin : g_out
                logic [32:0] w_mag;
                always_comb begin
                    w_mag    = (r_stg[k-1].q2 > (DIV2_WIDTH'(1) << 32)) ? 33'h1_0000_0000
                                                                       : r_stg[k-1].q2[32:0];
                    n_stg[k] = r_stg[k-1];
                    if (r_stg[k-1].zero_span) begin
                        n_stg[k].res = r_target_end;
                    end else if (r_stg[k-1].neg) begin
                        n_stg[k].res = w_mag[32] || w_mag[31] ? rme_pkg::SAT_MIN
                                                              : 32'(-w_mag[31:0]);
                    end else begin
                        n_stg[k].res = w_mag[32] || w_mag[31] ? rme_pkg::SAT_MAX
                                                              : w_mag[31:0];
                    end
                end
            end
        end
    endgenerate

endmodule

>>> rtl/rme_checker.sv
module rme_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_s_axis_tready,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [31:0] o_m_axis_tdata
);

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result shown straight after reset");

    // With no result held at the output the pipeline always has room.
    a_empty_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input refused while output is empty");

    // While the receiver takes results, input is never held back.
    a_flowing_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input refused while output is flowing");

    // A stalled result stays put.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed or vanished");

endmodule

bind range_map_with_easing_top rme_checker u_rme_checker (.*);

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT   = 40;
    localparam int STALL_LIMIT = 5000;

    // Scoreboard: holds its own copy of the register file and curve tables and
    // predicts each mapped value from the accepted reference value.
    class map_scoreboard;
        bit [31:0]  rs, re, ts, te;
        bit [2:0]   places, curve;
        bit [31:0]  ease_in [0:rme_pkg::CURVE_STEPS];
        bit [31:0]  ease_io [0:rme_pkg::CURVE_STEPS];
        bit [31:0]  pending [$];
        int         errors;
        int         checked;

        function new();
            bit [63:0] roots [0:30];
            bit [63:0] lg_s, a, n, f, g, res, v, x, x2, term, s;
            longint    sum;
            rs = 0; re = 65536; ts = 0; te = 65536; places = 1;
            curve = rme_pkg::CURVE_LINEAR;
            roots[0] = 0;
            roots[1] = isqrt(64'd1 << 61);
            for (int k = 2; k <= 30; k++) roots[k] = isqrt(roots[k-1] << 30);
            lg_s = log2_q30(rme_pkg::CURVE_STEPS);
            for (int i = 0; i <= rme_pkg::CURVE_STEPS; i++) begin
                if (i == 0) v = 0;
                else if (i == rme_pkg::CURVE_STEPS) v = 64'd1 << 30;
                else begin
                    a = ((lg_s - log2_q30(i)) * 64'd1675 + 64'd500) / 64'd1000;
                    n = a >> 30;
                    f = a & ((64'd1 << 30) - 1);
                    if (n > 40) v = 0;
                    else if (f == 0) v = (64'd1 << 30) >> n;
                    else begin
                        g = (64'd1 << 30) - f;
                        res = 64'd1 << 30;
                        for (int k = 1; k <= 30; k++)
                            if (g[30-k]) res = (res * roots[k]) >> 30;
                        v = res >> (n + 1);
                    end
                end
                ease_in[i] = v[31:0];

                if (i == 0) v = 0;
                else if (i == rme_pkg::CURVE_STEPS) v = 64'd1 << 30;
                else begin
                    x = (64'hC90F_DAA2 * 64'(i)) / 64'(2 * rme_pkg::CURVE_STEPS);
                    x2 = (x * x) >> 30;
                    term = x;
                    sum = longint'(x);
                    for (int k = 1; k <= 6; k++) begin
                        term = ((term * x2) >> 30) / 64'((2*k) * (2*k + 1));
                        if (k % 2 == 1) sum -= longint'(term);
                        else sum += longint'(term);
                    end
                    if (sum < 0) sum = 0;
                    if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
                    s = 64'(sum);
                    v = (s * s) >> 30;
                end
                ease_io[i] = v[31:0];
            end
        endfunction

        function bit [63:0] isqrt(bit [63:0] op);
            bit [63:0] res, one;
            res = 0;
            one = 64'd1 << 62;
            while (one > op) one >>= 2;
            while (one != 0) begin
                if (op >= res + one) begin
                    op -= res + one;
                    res = (res >> 1) + one;
                end else begin
                    res >>= 1;
                end
                one >>= 2;
            end
            return res;
        endfunction

        function bit [63:0] log2_q30(bit [63:0] n);
            int        e;
            bit [63:0] m, r;
            e = 0;
            r = 0;
            while (e < 63 && (n >> (e + 1)) != 0) e++;
            m = (n << 30) >> e;
            for (int k = 1; k <= 30; k++) begin
                m = (m * m) >> 30;
                if (m >= (64'd2 << 30)) begin
                    m >>= 1;
                    r |= 64'd1 << (30 - k);
                end
            end
            return (64'(e) << 30) + r;
        endfunction

        // Table value at the step below pct, interpolated toward the next step.
        function bit [63:0] shape(bit io_curve, bit [63:0] pct, bit mirrored);
            bit [63:0] pos, idx, fr, a, b;
            pos = pct * rme_pkg::CURVE_STEPS;
            idx = pos >> rme_pkg::FRAC_BITS;
            fr  = pos & ((64'd1 << rme_pkg::FRAC_BITS) - 1);
            if (idx >= rme_pkg::CURVE_STEPS) begin
                idx = rme_pkg::CURVE_STEPS;
                fr = 0;
            end
            if (mirrored) begin
                a = (64'd1 << 30) - ease_in[rme_pkg::CURVE_STEPS - idx];
                b = (idx < rme_pkg::CURVE_STEPS)
                  ? (64'd1 << 30) - ease_in[rme_pkg::CURVE_STEPS - idx - 1] : a;
            end else if (io_curve) begin
                a = ease_io[idx];
                b = (idx < rme_pkg::CURVE_STEPS) ? 64'(ease_io[idx + 1]) : a;
            end else begin
                a = ease_in[idx];
                b = (idx < rme_pkg::CURVE_STEPS) ? 64'(ease_in[idx + 1]) : a;
            end
            return (a * ((64'd1 << rme_pkg::FRAC_BITS) - fr) + b * fr) >> rme_pkg::FRAC_BITS;
        endfunction

        function bit [31:0] map_value(bit [31:0] ref_val);
            longint    srs, sre, sts, ste, den, num, x, r;
            bit [63:0] un, ud, pct, w, m, p, hp, lp, hi, k, mag;
            srs = longint'($signed(rs));
            sre = longint'($signed(re));
            sts = longint'($signed(ts));
            ste = longint'($signed(te));
            den = sre - srs;
            if (den == 0) return te;
            num = longint'($signed(ref_val)) - srs;
            un = 64'(num < 0 ? -num : num);
            ud = 64'(den < 0 ? -den : den);
            if (un >= ud) pct = 64'd1 << rme_pkg::FRAC_BITS;
            else pct = (un << rme_pkg::FRAC_BITS) / ud;
            case (curve)
                rme_pkg::CURVE_LINEAR:   w = pct << (30 - rme_pkg::FRAC_BITS);
                rme_pkg::CURVE_EASE_IN:  w = shape(0, pct, 0);
                rme_pkg::CURVE_EASE_OUT: w = shape(0, pct, 1);
                rme_pkg::CURVE_INSTANT:  w = 64'd1 << 30;
                default:                 w = shape(1, pct, 0);
            endcase
            x = sts * (longint'(1) << 30) + (ste - sts) * longint'(w);
            m = 64'(x < 0 ? -x : x);
            p = 1;
            for (int j = 0; j < (places > 4 ? 4 : places); j++) p *= 10;
            hp = (m >> 32) * p;
            lp = (m & 64'hFFFF_FFFF) * p;
            hi = hp + (lp >> 32) + (64'd1 << (rme_pkg::FRAC_BITS - 3));
            k = hi >> (rme_pkg::FRAC_BITS - 2);
            mag = ((k << rme_pkg::FRAC_BITS) + p / 2) / p;
            if (mag > (64'd1 << 32)) mag = 64'd1 << 32;
            r = (x < 0) ? -longint'(mag) : longint'(mag);
            if (r > longint'(2147483647)) r = longint'(2147483647);
            if (r < -longint'(2147483647) - 1) r = -longint'(2147483647) - 1;
            return r[31:0];
        endfunction

        function void set_reg(rme_pkg::t_reg_idx idx, bit [31:0] val);
            case (idx)
                rme_pkg::REG_REF_START:    rs = val;
                rme_pkg::REG_REF_END:      re = val;
                rme_pkg::REG_TARGET_START: ts = val;
                rme_pkg::REG_TARGET_END:   te = val;
                rme_pkg::REG_DEC_PLACES:   places = val[2:0];
                rme_pkg::REG_CURVE_KIND:   curve = val[2:0];
                default: ;
            endcase
        endfunction

        function void note_input(bit [31:0] ref_val);
            pending.push_back(map_value(ref_val));
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(bit [31:0] got);
            bit [31:0] want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected mapped_value %h", got));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want)
                report($sformatf("mapped_value got %h want %h", got, want));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] in_data;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    map_scoreboard sb;
    bit            calm;
    int            idle_cycles;
    int            sent;
    int            phases;

    range_map_with_easing_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver stalls at random unless a calm stretch is running.
    always @(negedge i_clk) begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && out_ready) sb.check_result(out_data);
            if ((out_valid && out_ready) || (in_valid && in_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic write_reg(rme_pkg::t_reg_idx idx, bit [31:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // The valid line is only ever changed at a falling edge; it stays high
    // between back-to-back transactions.
    task automatic send(bit [31:0] ref_val);
        @(negedge i_clk);
        if (!calm) begin
            while ($urandom_range(99) < 8) begin
                in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= ref_val;
        do @(posedge i_clk); while (!in_ready);
        sb.note_input(ref_val);
        sent++;
    endtask

    // Waits until every mapped value is back, so the pipeline is empty.
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic configure(bit [31:0] r0, bit [31:0] r1, bit [31:0] t0, bit [31:0] t1,
                             bit [2:0] dp, bit [2:0] ck);
        drain();
        write_reg(rme_pkg::REG_REF_START, r0);
        write_reg(rme_pkg::REG_REF_END, r1);
        write_reg(rme_pkg::REG_TARGET_START, t0);
        write_reg(rme_pkg::REG_TARGET_END, t1);
        write_reg(rme_pkg::REG_DEC_PLACES, {29'd0, dp});
        write_reg(rme_pkg::REG_CURVE_KIND, {29'd0, ck});
        phases++;
    endtask

    function automatic bit [31:0] pick_ref();
        longint lo, hi, span;
        if ($urandom_range(99) < 25) return $urandom();
        lo = longint'($signed(sb.rs));
        hi = longint'($signed(sb.re));
        span = hi - lo;
        // Mostly inside the source range, with a little overshoot on both ends.
        return 32'(lo + (span * longint'($urandom_range(1100))) / 1000
                   - span / 20);
    endfunction

    function automatic bit [31:0] pick_bound();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(400)) - 200) << 16;
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(20000)) - 10000) * 7;
        endcase
    endfunction

    initial begin
        bit [31:0] directed [11];
        directed = '{32'h0, 32'h1_0000, 32'h8000, 32'hFFFF_FFFF,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h2_0000,
                     32'hFFFF_0000, 32'h4000, 32'hC000, 32'h1};
        sb = new();
        calm = 1'b0;
        idle_cycles = 0;
        sent = 0;
        phases = 0;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings, then every curve and place count over the unit range.
        foreach (directed[i]) send(directed[i]);
        for (int ck = 0; ck < 8; ck++) begin
            configure(32'h0, 32'h1_0000, 32'hFFFE_0000, 32'h3_0000, 3'(ck), 3'(ck));
            send(32'h0); send(32'h5555); send(32'hC000); send(32'h1_0000);
        end
        // Widest ranges, a falling source range, and a zero source span.
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 3'd4, 3'd0);
        foreach (directed[i]) send(directed[i]);
        configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 3'd0, 3'd4);
        foreach (directed[i]) send(directed[i]);
        configure(32'h1234_5678, 32'h1234_5678, 32'h0, 32'h8765_4321, 3'd2, 3'd1);
        send(32'h1234_5678); send(32'h0);

        for (int ph = 0; ph < 12; ph++) begin
            configure(pick_bound(), pick_bound(), pick_bound(), pick_bound(),
                      3'($urandom_range(7)), 3'(ph % 8));
            calm = (ph == 5);
            for (int i = 0; i < 53; i++) send(pick_ref());
            calm = 1'b0;
        end

        drain();
        $display("Sent %0d reference values over %0d register settings, %0d results checked.",
                 sent, phases, sb.checked);
        $display("Covered all curve kinds, 0-7 decimal places, extreme and zero-span ranges.");
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
